>>> rtl/lz_rle_stream_decompressor_macros.svh
// Assertion macros for the stream decompressor.
`ifndef LZ_RLE_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_RLE_STREAM_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define LZRLE_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lzrle assertion failed");
// ante at one edge implies cons at the next edge
`define LZRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzrle assertion failed");
`else
`define LZRLE_ASSERT(label, clk, rst, cond)
`define LZRLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lzrle_pkg.sv
package lzrle_pkg;
  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int OUTPUT_LANES = 8;
  localparam int POS_W = 24;
  localparam logic [POS_W-1:0] POS_MAX = 24'hFFFFFF;
  // command class boundaries
  localparam logic [7:0] CMD_RAW = 8'h80;
  localparam logic [7:0] CMD_RUN = 8'hC0;
  localparam logic [7:0] CMD_ZRUN = 8'hE0;
  localparam logic [7:0] CMD_LONG = 8'hFF;
endpackage

>>> rtl/lzrle_ram.sv
module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/lz_rle_stream_decompressor.sv
// Byte-serial LZ77/RLE decompressor with a 1024-byte history window. Each
// input item is one compressed byte; decoded bytes leave packed up to eight
// per result, last_of_run marking the final result of an input item and
// end_of_stream the item that finishes the stream. Header bytes and command
// bytes that only wait for an operand leave the input ready for another
// byte. A byte that yields output holds the input while each decoded byte
// of a run or literal is written, and each window-copy byte is read from
// history and then written back through the separate write port of the
// history memory; full results are handed on before the last, and the
// input is freed once the final result is closed. A zero run can be up to
// 257 bytes; a byte that only ends the stream still closes an empty result.
// A restart needs no clearing pass: the write index and a wrap flag mark which
// history entries were written since the stream began.
`include "lz_rle_stream_decompressor_macros.svh"
module lz_rle_stream_decompressor #(
  parameter int HISTORY_DEPTH = lzrle_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       start_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_0,
  output logic [7:0] out_byte_1,
  output logic [7:0] out_byte_2,
  output logic [7:0] out_byte_3,
  output logic [7:0] out_byte_4,
  output logic [7:0] out_byte_5,
  output logic [7:0] out_byte_6,
  output logic [7:0] out_byte_7,
  output logic [3:0] byte_count,
  output logic       last_of_run,
  output logic       end_of_stream
);
  import lzrle_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_CMD, P_OPND, P_LIT, P_DONE
  } phase_t;
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  phase_t           phase, phase_next;
  state_t           state;
  logic [POS_W-1:0] pos, pos_next, pos_inc, len, len_next;
  logic [7:0]       pcmd, pcmd_next;
  logic [4:0]       lits, lits_next;
  logic             restart, bnd, fin;
  logic [8:0]       gen_n;
  logic [7:0]       gen_val;
  logic             gen_copy;
  logic [9:0]       gen_dist;

  // sequencer registers
  logic [8:0]    remaining;
  logic [7:0]    run_val;
  logic          copy, ph, finish, rd_ok, wrapped;
  logic [AW-1:0] copy_dist, wi;
  logic [7:0]    pack [OUTPUT_LANES];
  logic [3:0]    pcnt;

  // output register
  logic [7:0] ob [OUTPUT_LANES];
  logic [3:0] ocnt;
  logic       olast, oend, ovalid;

  logic          accept, can_load, load, step, we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata, wdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_load = !ovalid || !out_stall;
  assign load     = can_load && ((state == S_FLUSH) ||
                    (state == S_RUN && remaining != 9'd0 &&
                     pcnt == 4'(OUTPUT_LANES)));

  // parser: one compressed byte
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    len_next   = len;
    pcmd_next  = pcmd;
    lits_next  = lits;
    restart    = 1'b0;
    bnd        = 1'b0;
    gen_n      = '0;
    gen_val    = in_byte;
    gen_copy   = 1'b0;
    gen_dist   = '0;
    pos_inc    = (pos == POS_MAX) ? pos : pos + POS_W'(1);
    if (start_of_stream || phase == P_HDR0) begin
      restart    = 1'b1;
      pos_next   = POS_W'(1);
      len_next   = '0;
      pcmd_next  = '0;
      lits_next  = '0;
      phase_next = P_HDR1;
    end else if (phase != P_DONE) begin
      pos_next = pos_inc;
      case (phase)
        P_HDR1: begin
          len_next   = {in_byte, 16'h0000};
          phase_next = P_HDR2;
        end
        P_HDR2: begin
          len_next   = {len[23:16], in_byte, len[7:0]};
          phase_next = P_HDR3;
        end
        P_HDR3: begin
          len_next = {len[23:8], in_byte};
          bnd      = 1'b1;
        end
        P_CMD: begin
          pcmd_next = in_byte;
          if (in_byte < CMD_RAW) begin
            phase_next = P_OPND;
          end else if (in_byte < CMD_RUN) begin
            lits_next = in_byte[4:0];
            if (in_byte[4:0] != 5'd0) begin
              phase_next = P_LIT;
            end else begin
              bnd = 1'b1;
            end
          end else if (in_byte < CMD_ZRUN || in_byte == CMD_LONG) begin
            phase_next = P_OPND;
          end else begin
            gen_n   = {4'd0, in_byte[4:0]} + 9'd2;
            gen_val = '0;
            bnd     = 1'b1;
          end
        end
        P_OPND: begin
          if (pcmd < CMD_RAW) begin
            gen_copy = 1'b1;
            gen_n    = {4'd0, pcmd[6:2]} + 9'd2;
            gen_dist = {pcmd[1:0], in_byte};
          end else if (pcmd == CMD_LONG) begin
            gen_n   = {1'b0, in_byte} + 9'd2;
            gen_val = '0;
          end else begin
            gen_n = {4'd0, pcmd[4:0]} + 9'd2;
          end
          bnd = 1'b1;
        end
        P_LIT: begin
          gen_n     = 9'd1;
          lits_next = lits - 5'd1;
          if (lits == 5'd1) begin
            bnd = 1'b1;
          end
        end
        default: ;
      endcase
      if (bnd) begin
        phase_next = (pos_inc >= len_next) ? P_DONE : P_CMD;
      end
    end
    fin = bnd && (pos_inc >= len_next);
  end

  // byte generation and history access
  assign step  = (state == S_RUN) && (remaining != 9'd0) &&
                 (pcnt != 4'(OUTPUT_LANES));
  assign we    = step && (!copy || ph);
  assign raddr = wi - copy_dist;
  assign wdata = copy ? (rd_ok ? rdata : 8'h00) : run_val;

  lzrle_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wi),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer, parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_HDR0;
      state     <= S_IDLE;
      pos       <= '0;
      len       <= '0;
      pcmd      <= '0;
      lits      <= '0;
      wi        <= '0;
      wrapped   <= 1'b0;
      remaining <= '0;
      pcnt      <= '0;
      ph        <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      if (ovalid && !out_stall && !load) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            phase     <= phase_next;
            pos       <= pos_next;
            len       <= len_next;
            pcmd      <= pcmd_next;
            lits      <= lits_next;
            remaining <= gen_n;
            run_val   <= gen_val;
            copy      <= gen_copy;
            copy_dist <= gen_dist[AW-1:0];
            finish    <= fin;
            pcnt      <= '0;
            ph        <= 1'b0;
            if (restart) begin
              wi      <= '0;
              wrapped <= 1'b0;
            end
            if (gen_n != 9'd0) begin
              state <= S_RUN;
            end else if (fin) begin
              state <= S_FLUSH;
            end
          end
        end
        S_RUN: begin
          if (remaining == 9'd0) begin
            state <= S_FLUSH;
          end else if (pcnt == 4'(OUTPUT_LANES)) begin
            if (can_load) begin
              ob     <= pack;
              ocnt   <= pcnt;
              olast  <= 1'b0;
              oend   <= 1'b0;
              ovalid <= 1'b1;
              pcnt   <= '0;
            end
          end else if (copy && !ph) begin
            rd_ok <= wrapped || (raddr < wi);
            ph    <= 1'b1;
          end else begin
            pack[pcnt[2:0]] <= wdata;
            pcnt      <= pcnt + 4'd1;
            remaining <= remaining - 9'd1;
            wi        <= wi + AW'(1);
            ph        <= 1'b0;
            if (wi == AW'(HISTORY_DEPTH - 1)) begin
              wrapped <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (can_load) begin
            ob     <= pack;
            ocnt   <= pcnt;
            olast  <= 1'b1;
            oend   <= finish;
            ovalid <= 1'b1;
            pcnt   <= '0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // unused lanes read as zero
  always_comb begin
    out_byte_0 = (ocnt > 4'd0) ? ob[0] : 8'h00;
    out_byte_1 = (ocnt > 4'd1) ? ob[1] : 8'h00;
    out_byte_2 = (ocnt > 4'd2) ? ob[2] : 8'h00;
    out_byte_3 = (ocnt > 4'd3) ? ob[3] : 8'h00;
    out_byte_4 = (ocnt > 4'd4) ? ob[4] : 8'h00;
    out_byte_5 = (ocnt > 4'd5) ? ob[5] : 8'h00;
    out_byte_6 = (ocnt > 4'd6) ? ob[6] : 8'h00;
    out_byte_7 = (ocnt > 4'd7) ? ob[7] : 8'h00;
  end

  assign out_valid     = ovalid;
  assign byte_count    = ocnt;
  assign last_of_run   = olast;
  assign end_of_stream = oend;

  `LZRLE_ASSERT(a_pack_bound, clk, rst, pcnt <= 4'(OUTPUT_LANES))
  `LZRLE_ASSERT(a_end_is_last, clk, rst, !ovalid || !oend || olast)
  `LZRLE_ASSERT_NEXT(a_full_pack_pushed, clk, rst,
    state == S_RUN && remaining != 9'd0 && pcnt == 4'(OUTPUT_LANES) && can_load,
    ovalid && !olast && ocnt == 4'(OUTPUT_LANES))
endmodule
